// ----- hw/rtl/ffha_pkg.sv -----
// Shared constants and types for the first-fit heap allocator.
package ffha_pkg;

  localparam int unsigned HEAP_BYTES_DEF   = 16384;
  localparam int unsigned PAGE_BYTES_DEF   = 4096;
  localparam int unsigned HEADER_BYTES_DEF = 8;
  localparam int unsigned MIN_BLOCK        = 16;

  localparam int unsigned REQ_W    = 15;
  localparam int unsigned UOFF_W   = 16;
  localparam int unsigned RES_W    = 15;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned BUDGET_W = 3;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_HDR  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HEAP_LIM  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_PAGES  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BELOW     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_ABOVE     = 3'd6;
  localparam logic [STATUS_W-1:0] ST_HALTED    = 3'd7;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic we;
    logic re;
  } ffha_mem_ctl_t;

endpackage

// ----- hw/rtl/ffha_mem.sv -----
// Header store: single-port memory with registered read data.
module ffha_mem import ffha_pkg::*; #(
  parameter int unsigned AW = 14,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  ffha_mem_ctl_t ctl,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
    if (ctl.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/ffha_seq.sv -----
// Sequencer and shared adder that walk, grow, split and merge heap blocks.
module ffha_seq import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int unsigned AW = $clog2(HEAP_BYTES),
  localparam int unsigned SW = AW + 1,
  localparam int unsigned DW = SW + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [REQ_W-1:0]    in_request_size,
  input  logic [UOFF_W-1:0]   in_user_offset,
  input  logic                in_is_null,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RES_W-1:0]    out_result_offset,
  output logic [STATUS_W-1:0] out_status,
  input  logic [BUDGET_W-1:0] budget,
  output ffha_mem_ctl_t       mem_ctl,
  output logic [AW-1:0]       mem_addr,
  output logic [DW-1:0]       mem_wdata,
  input  logic [DW-1:0]       mem_rdata
);

  localparam int unsigned PG_SH = $clog2(PAGE_BYTES);
  localparam int unsigned XW    = $clog2(HEAP_BYTES + 32768 + PAGE_BYTES) + 2;
  localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);
  localparam logic [XW-1:0] HDR_X  = XW'(HEADER_BYTES);
  localparam logic [XW-1:0] MIN_X  = XW'(MIN_BLOCK);

  typedef enum logic [3:0] {
    S_IDLE, S_GROW, S_WRD, S_WCHK, S_WADV, S_SPLIT, S_SPLIT2,
    S_FRD, S_FCHK, S_FNX, S_FNCHK, S_FSUM, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic [XW-1:0]         real_r, real_nxt;
  logic [XW-1:0]         blk_r, blk_nxt;
  logic [XW-1:0]         aux_r, aux_nxt;     // rest size or merge cursor
  logic [XW-1:0]         bsize_r, bsize_nxt;
  logic [XW-1:0]         npages_r, npages_nxt;
  logic [XW-1:0]         top_r, top_nxt;
  logic [BUDGET_W-1:0]   pages_r, pages_nxt;
  logic                  halted_r, halted_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]      result_r, result_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic [RES_W-1:0]      out_result_r, out_result_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  // shared adder
  logic [XW-1:0] alu_a, alu_b, alu_y;
  logic          alu_sub;
  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  logic [XW-1:0] rd_size, amount, sat_sum;
  logic          rd_used;
  assign rd_size = XW'(mem_rdata[SW-1:0]);
  assign rd_used = mem_rdata[SW];
  assign amount  = npages_r << PG_SH;
  assign sat_sum = (alu_y > HEAP_X) ? HEAP_X : alu_y;

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_result_offset = out_result_r;
  assign out_status        = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    real_nxt       = real_r;
    blk_nxt        = blk_r;
    aux_nxt        = aux_r;
    bsize_nxt      = bsize_r;
    npages_nxt     = npages_r;
    top_nxt        = top_r;
    pages_nxt      = pages_r;
    halted_nxt     = halted_r;
    out_valid_nxt  = out_valid_r && out_stall;
    result_nxt     = result_r;
    status_nxt     = status_r;
    out_result_nxt = out_result_r;
    out_status_nxt = out_status_r;
    alu_a          = '0;
    alu_b          = '0;
    alu_sub        = 1'b0;
    mem_ctl        = '0;
    mem_addr       = blk_r[AW-1:0];
    mem_wdata      = '0;

    unique case (state_r)
      S_IDLE: begin
        npages_nxt = (XW'(in_request_size) >> PG_SH) + XW'(1);
        blk_nxt    = '0;
        result_nxt = '0;
        if (in_operation == OP_ALLOC) begin
          alu_a = XW'(in_request_size);
          alu_b = HDR_X;
        end else begin
          alu_a   = XW'(in_user_offset);
          alu_b   = HDR_X;
          alu_sub = 1'b1;
        end
        if (in_valid) begin
          state_nxt = S_DONE;
          if (halted_r) begin
            status_nxt = ST_HALTED;
          end else if (in_operation == OP_ALLOC) begin
            real_nxt = (alu_y < MIN_X) ? MIN_X : alu_y;
            if (in_request_size == '0) begin
              status_nxt = ST_NULL;
            end else if (top_r == '0) begin
              state_nxt = S_GROW;
            end else begin
              state_nxt = S_WRD;
            end
          end else if (in_is_null) begin
            status_nxt = ST_NULL;
          end else if (XW'(in_user_offset) < HDR_X) begin
            status_nxt = ST_BELOW;
            halted_nxt = 1'b1;
          end else if (XW'(in_user_offset) > HEAP_X) begin
            status_nxt = ST_ABOVE;
            halted_nxt = 1'b1;
          end else begin
            blk_nxt   = alu_y;
            state_nxt = S_FRD;
          end
        end
      end
      S_GROW: begin
        alu_a = top_r;
        alu_b = amount;
        if (alu_y > HEAP_X) begin
          status_nxt = ST_HEAP_LIM;
          halted_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else if (XW'(pages_r) + npages_r > XW'(budget)) begin
          status_nxt = ST_NO_PAGES;
          halted_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          mem_ctl.we = 1'b1;
          mem_addr   = top_r[AW-1:0];
          mem_wdata  = {1'b0, amount[SW-1:0]};
          top_nxt    = alu_y;
          pages_nxt  = pages_r + npages_r[BUDGET_W-1:0];
          state_nxt  = S_WRD;
        end
      end
      S_WRD: begin
        mem_ctl.re = 1'b1;
        state_nxt  = S_WCHK;
      end
      S_WCHK: begin
        bsize_nxt = rd_size;
        if (!rd_used && real_r <= rd_size) begin
          alu_a     = rd_size;
          alu_b     = real_r;
          alu_sub   = 1'b1;
          aux_nxt   = alu_y;
          state_nxt = S_SPLIT;
        end else if (rd_size == '0) begin
          status_nxt = ST_ZERO_HDR;
          halted_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          alu_a     = blk_r;
          alu_b     = rd_size;
          blk_nxt   = alu_y;
          state_nxt = S_WADV;
        end
      end
      S_WADV: begin
        if (blk_r == top_r) begin
          state_nxt = S_GROW;
        end else if (blk_r >= HEAP_X) begin
          status_nxt = ST_HEAP_LIM;
          halted_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_SPLIT: begin
        mem_ctl.we = 1'b1;
        alu_a      = blk_r;
        alu_b      = HDR_X;
        result_nxt = alu_y[RES_W-1:0];
        status_nxt = ST_OK;
        if (aux_r < MIN_X) begin
          mem_wdata = {1'b1, bsize_r[SW-1:0]};
          state_nxt = S_DONE;
        end else begin
          mem_wdata = {1'b1, real_r[SW-1:0]};
          state_nxt = S_SPLIT2;
        end
      end
      S_SPLIT2: begin
        alu_a     = blk_r;
        alu_b     = real_r;
        mem_addr  = alu_y[AW-1:0];
        mem_wdata = {1'b0, aux_r[SW-1:0]};
        // drop a header write beyond the heap
        mem_ctl.we = (alu_y < HEAP_X);
        state_nxt  = S_DONE;
      end
      S_FRD: begin
        mem_ctl.re = 1'b1;
        state_nxt  = S_FCHK;
      end
      S_FCHK: begin
        if (rd_size == '0) begin
          status_nxt = ST_ZERO_HDR;
          halted_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          mem_ctl.we = 1'b1;
          mem_wdata  = {1'b0, rd_size[SW-1:0]};
          bsize_nxt  = rd_size;
          alu_a      = blk_r;
          alu_b      = rd_size;
          aux_nxt    = alu_y;
          state_nxt  = S_FNX;
        end
      end
      S_FNX: begin
        if (aux_r < top_r) begin
          mem_ctl.re = 1'b1;
          mem_addr   = aux_r[AW-1:0];
          state_nxt  = S_FNCHK;
        end else begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_FNCHK: begin
        alu_a = bsize_r;
        alu_b = rd_size;
        if (rd_used) begin
          status_nxt = ST_OK;
          state_nxt  = S_DONE;
        end else if (rd_size == '0) begin
          status_nxt = ST_ZERO_HDR;
          halted_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          mem_ctl.we = 1'b1;
          mem_wdata  = {1'b0, sat_sum[SW-1:0]};
          bsize_nxt  = sat_sum;
          state_nxt  = S_FSUM;
        end
      end
      S_FSUM: begin
        alu_a     = blk_r;
        alu_b     = bsize_r;
        aux_nxt   = alu_y;
        state_nxt = S_FNX;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_result_nxt = (status_r != ST_OK) ? '0 : result_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      pages_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      pages_r     <= pages_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    real_r       <= real_nxt;
    blk_r        <= blk_nxt;
    aux_r        <= aux_nxt;
    bsize_r      <= bsize_nxt;
    npages_r     <= npages_nxt;
    result_r     <= result_nxt;
    status_r     <= status_nxt;
    out_result_r <= out_result_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= HEAP_X) else $error("heap top beyond heap");
  a_top_align: assert property (@(posedge clk) disable iff (!rst_n)
    top_r[PG_SH-1:0] == '0) else $error("heap top not page aligned");
  a_err_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> out_result_r == '0)
    else $error("nonzero offset with error status");
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r) else $error("halt cleared without reset");
`endif

endmodule

// ----- hw/rtl/first_fit_heap_allocator.sv -----
// Allocate walks the headers, grows the heap when it reaches the top and splits the fitting
// block; free marks the block free and merges following free neighbors until a used one.
// Throughput: one item at a time; the single-port header store and the shared adder
// set the walk rate. Output register lets a new item start while a result waits.
// Reset: synchronous active-low rst_n clears heap top, page count and halt, sets budget to 4;
// the header store is not cleared.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = HEAP_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_operation,
  input  logic [REQ_W-1:0]    in_request_size,
  input  logic [UOFF_W-1:0]   in_user_offset,
  input  logic                in_is_null,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [RES_W-1:0]    out_result_offset,
  output logic [STATUS_W-1:0] out_status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [BUDGET_W-1:0] cfg_page_budget
);

  localparam int unsigned AW = $clog2(HEAP_BYTES);
  localparam int unsigned DW = AW + 2;

  logic [BUDGET_W-1:0] budget_r;
  ffha_mem_ctl_t       mem_ctl;
  logic [AW-1:0]       mem_addr;
  logic [DW-1:0]       mem_wdata, mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= BUDGET_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      budget_r <= cfg_page_budget;
    end
  end

  ffha_seq #(
    .HEAP_BYTES  (HEAP_BYTES),
    .PAGE_BYTES  (PAGE_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_request_size  (in_request_size),
    .in_user_offset   (in_user_offset),
    .in_is_null       (in_is_null),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_offset(out_result_offset),
    .out_status       (out_status),
    .budget           (budget_r),
    .mem_ctl          (mem_ctl),
    .mem_addr         (mem_addr),
    .mem_wdata        (mem_wdata),
    .mem_rdata        (mem_rdata)
  );

  ffha_mem #(
    .AW(AW),
    .DW(DW)
  ) u_mem (
    .clk  (clk),
    .ctl  (mem_ctl),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

// ----- bench/first_fit_heap_allocator_test.sv -----
// Self-checking bench for the first-fit heap allocator: legal alloc/free traffic, budget phases, halt.
module first_fit_heap_allocator_test;
  import ffha_pkg::*;

  localparam int unsigned HEAP = HEAP_BYTES_DEF;
  localparam int unsigned PAGE = PAGE_BYTES_DEF;
  localparam int unsigned HDR  = HEADER_BYTES_DEF;

  typedef struct {
    logic [RES_W-1:0]    offset;
    logic [STATUS_W-1:0] status;
  } alloc_result_t;

  class alloc_scoreboard;
    alloc_result_t expected_q[$];

    function void note_request(alloc_result_t r);
      expected_q.push_back(r);
    endfunction

    // Return an empty string on a match, else a description of the mismatch.
    function string check_result(logic [RES_W-1:0] offset, logic [STATUS_W-1:0] status);
      alloc_result_t e;
      if (expected_q.size() == 0)
        return $sformatf("unexpected result offset=%0d status=%0d", offset, status);
      e = expected_q.pop_front();
      if (offset !== e.offset || status !== e.status)
        return $sformatf("result offset=%0d status=%0d, expected offset=%0d status=%0d",
                         offset, status, e.offset, e.status);
      return "";
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = OP_ALLOC;
  logic [REQ_W-1:0]    in_request_size = '0;
  logic [UOFF_W-1:0]   in_user_offset = '0;
  logic                in_is_null = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [RES_W-1:0]    out_result_offset;
  logic [STATUS_W-1:0] out_status;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [BUDGET_W-1:0] cfg_page_budget = 3'd4;

  first_fit_heap_allocator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_request_size(in_request_size), .in_user_offset(in_user_offset),
    .in_is_null(in_is_null),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_offset(out_result_offset), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_page_budget(cfg_page_budget)
  );

  alloc_scoreboard sb = new();

  // Heap image and allocator state mirrored by the bench.
  int unsigned hsize [HEAP];
  bit          hused [HEAP];
  int unsigned heap_top, pages_used, budget;
  bit          halted;
  // Undo log for trial runs.
  bit          trial_on;
  int unsigned undo_at[$], undo_size[$];
  bit          undo_used[$];

  int unsigned live_q[$];
  int n_items, n_results, n_errors, n_alloc_ok, n_merges_freed;
  int tx_pct, rx_pct, hold_req, hold_done, hold_left;

  task automatic report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic void put_header(int unsigned at, int unsigned size, bit used);
    if (at < HEAP) begin
      if (trial_on) begin
        undo_at.push_back(at);
        undo_size.push_back(hsize[at]);
        undo_used.push_back(hused[at]);
      end
      hsize[at] = size;
      hused[at] = used;
    end
  endfunction

  function automatic int grow_heap(int unsigned npages);
    int unsigned base;
    base = heap_top;
    if (heap_top + npages * PAGE > HEAP) return ST_HEAP_LIM;
    for (int i = 0; i < npages; i++) begin
      if (pages_used >= budget) return ST_NO_PAGES;
      pages_used++;
      heap_top += PAGE;
    end
    put_header(base, npages * PAGE, 1'b0);
    return ST_OK;
  endfunction

  function automatic int walk_alloc(int unsigned req, output int unsigned res);
    int unsigned need, blk, rest;
    int st;
    res = 0;
    if (req == 0) return ST_NULL;
    need = HDR + req;
    if (need < MIN_BLOCK) need = MIN_BLOCK;
    if (heap_top == 0) begin
      st = grow_heap(req / PAGE + 1);
      if (st != ST_OK) return st;
    end
    blk = 0;
    while (hused[blk] || need > hsize[blk]) begin
      if (hsize[blk] == 0) return ST_ZERO_HDR;
      blk += hsize[blk];
      if (blk == heap_top) begin
        st = grow_heap(req / PAGE + 1);
        if (st != ST_OK) return st;
      end else if (blk >= HEAP) begin
        return ST_HEAP_LIM;
      end
    end
    rest = hsize[blk] - need;
    if (rest < MIN_BLOCK) begin
      put_header(blk, hsize[blk], 1'b1);
    end else begin
      put_header(blk + need, rest, 1'b0);
      put_header(blk, need, 1'b1);
    end
    res = blk + HDR;
    return ST_OK;
  endfunction

  function automatic int free_merge(int unsigned off, bit nul);
    int unsigned blk, nxt, sum;
    if (nul) return ST_NULL;
    if (off < HDR) return ST_BELOW;
    if (off > HEAP) return ST_ABOVE;
    blk = off - HDR;
    if (hsize[blk] == 0) return ST_ZERO_HDR;
    put_header(blk, hsize[blk], 1'b0);
    nxt = blk + hsize[blk];
    while (nxt < heap_top && !hused[nxt]) begin
      if (hsize[nxt] == 0) return ST_ZERO_HDR;
      sum = hsize[blk] + hsize[nxt];
      if (sum > HEAP) sum = HEAP;
      put_header(blk, sum, 1'b0);
      nxt = blk + sum;
    end
    return ST_OK;
  endfunction

  function automatic alloc_result_t predict_step(bit op, int unsigned req, int unsigned off,
                                                 bit nul);
    alloc_result_t r;
    int unsigned res;
    int st;
    res = 0;
    if (halted) begin
      st = ST_HALTED;
    end else begin
      if (op == OP_ALLOC) st = walk_alloc(req, res);
      else st = free_merge(off, nul);
      if (st >= ST_ZERO_HDR) begin
        halted = 1'b1;
        res = 0;
      end
    end
    r.offset = res[RES_W-1:0];
    r.status = st[STATUS_W-1:0];
    return r;
  endfunction

  // Run an item against the mirror, then roll everything back.
  function automatic logic [STATUS_W-1:0] trial_status(bit op, int unsigned req,
                                                       int unsigned off, bit nul);
    alloc_result_t r;
    int unsigned s_top, s_pages;
    bit s_halt;
    s_top = heap_top; s_pages = pages_used; s_halt = halted;
    undo_at.delete(); undo_size.delete(); undo_used.delete();
    trial_on = 1'b1;
    r = predict_step(op, req, off, nul);
    trial_on = 1'b0;
    while (undo_at.size() > 0) begin
      hsize[undo_at[$]] = undo_size.pop_back();
      hused[undo_at.pop_back()] = undo_used.pop_back();
    end
    heap_top = s_top; pages_used = s_pages; halted = s_halt;
    return r.status;
  endfunction

  task automatic send_item(bit op, int unsigned req, int unsigned off, bit nul);
    alloc_result_t r;
    if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_operation    <= op;
    in_request_size <= req[REQ_W-1:0];
    in_user_offset  <= off[UOFF_W-1:0];
    in_is_null      <= nul;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    r = predict_step(op, req, off, nul);
    sb.note_request(r);
    n_items++;
    if (op == OP_ALLOC && r.status == ST_OK) begin
      live_q.push_back(r.offset);
      n_alloc_ok++;
    end
  endtask

  // Free the live allocation at the given index; drop it from the live list.
  task automatic free_live(int idx);
    int unsigned off;
    off = live_q[idx];
    live_q.delete(idx);
    n_merges_freed++;
    send_item(OP_FREE, $urandom_range(0, 32767), off, 1'b0);
  endtask

  // Pick a legal item with random content; never let the block halt here.
  task automatic send_random();
    int unsigned req, r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_item(OP_ALLOC, 0, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
    end else if (r < 10) begin
      send_item(OP_FREE, $urandom_range(0, 32767), $urandom_range(0, 65535), 1'b1);
    end else if (r < 48 && live_q.size() > 0) begin
      free_live($urandom_range(0, live_q.size() - 1));
    end else begin
      req = ($urandom_range(0, 9) == 0) ? $urandom_range(257, 9000) : $urandom_range(1, 256);
      if (trial_status(OP_ALLOC, req, 0, 1'b0) < ST_ZERO_HDR)
        send_item(OP_ALLOC, req, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
      else if (live_q.size() > 0)
        free_live($urandom_range(0, live_q.size() - 1));
      else
        send_item(OP_FREE, req, $urandom_range(0, 65535), 1'b1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.waiting() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_budget(int unsigned value);
    cfg_page_budget <= value[BUDGET_W-1:0];
    cfg_valid       <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    budget = value;
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: check each transfer, stall at random or for a requested long hold.
  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && !out_stall) begin
      msg = sb.check_result(out_result_offset, out_status);
      if (msg != "") report(msg);
      n_results++;
    end
    if (hold_req != hold_done) begin
      hold_done = hold_req;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= (rx_pct > 0 && $urandom_range(0, 99) < rx_pct);
    end
  end

  initial begin
    int budgets[6] = '{4, 2, 0, 3, 1, 4};
    int modes_tx[3] = '{16, 60, 0};
    int modes_rx[3] = '{60, 16, 0};
    heap_top = 0; pages_used = 0; halted = 0; budget = 4; trial_on = 0;
    tx_pct = 0; rx_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_budget(4);

    // Directed: null cases, minimum block, first growth, exact fits, merges.
    send_item(OP_ALLOC, 0, 16'hFFFF, 1'b1);
    send_item(OP_FREE, 15'h7FFF, 16'hFFFF, 1'b1);
    send_item(OP_ALLOC, 1, 0, 0);
    send_item(OP_ALLOC, 8, 0, 0);
    send_item(OP_ALLOC, 9, 0, 0);
    send_item(OP_ALLOC, 4000, 0, 0);
    send_item(OP_ALLOC, 100, 0, 0);
    free_live(1);
    free_live(0);
    send_item(OP_ALLOC, 16, 0, 0);
    send_item(OP_ALLOC, 8, 0, 0);
    send_item(OP_ALLOC, 7000, 0, 0);
    while (live_q.size() > 0) free_live(live_q.size() - 1);
    send_item(OP_ALLOC, 4088, 0, 0);
    free_live(0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      write_budget(budgets[ph]);
      tx_pct = modes_tx[ph % 3];
      rx_pct = modes_rx[ph % 3];
      if (ph == 2) hold_req++;
      for (int i = 0; i < 170; i++) begin
        send_random();
        // Let the pipeline empty completely once mid-phase.
        if (ph == 1 && i == 80) wait_drained();
      end
      wait_drained();
    end

    // Fatal free below the heap halts the block; everything after reports halted.
    send_item(OP_FREE, 0, $urandom_range(0, HDR - 1), 1'b0);
    for (int i = 0; i < 20; i++)
      send_item(1'($urandom_range(0, 1)), (i == 0) ? HEAP : $urandom_range(0, 32767),
                $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
    send_item(OP_FREE, 15'h7FFF, 16'h8000, 1'b0);
    wait_drained();
    repeat (50) @(posedge clk);

    $display("Covered %0d requests (%0d allocations granted, %0d frees of live blocks),",
             n_items, n_alloc_ok, n_merges_freed);
    $display("page budgets 0 to 4, stall patterns, a long output hold and a final halt.");
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
